### hw/rtl/scp_pkg.sv
package scp_pkg;

  localparam int unsigned SECTION_LIMIT_DEF = 8;
  localparam int unsigned NAME_LIMIT = 64;

  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Magic "DLCr", first byte in the low lane.
  localparam logic [31:0] MAGIC_WORD = 32'h7243_4C44;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_IGN  = 2'd3;

  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_NAME  = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  localparam logic [ADDR_W-3:0] REG_TOTAL_LENGTH = '0;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_req;
  } scp_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] section_index;
    logic [7:0] value;
    logic       section_done;
    logic [2:0] status;
  } scp_out_t;

endpackage

### hw/rtl/section_container_parser.sv
// Channel | Ports                          | Item
// input   | in_valid, in_ready, in_data    | one container byte and a restart flag
// output  | out_valid, out_ready, out_data | byte tag, section, value, done mark, status
// config  | psel, penable, pwrite, paddr   | total_length at byte address 0
//
// Each item passes from acceptance through the input register and then the result
// register, and one item is accepted per cycle while the output is not stalled.
// The parser state advances once per byte, which sets this rate.
// Reset is synchronous and active low; it clears the parser and total_length.
// A stalled result holds the input register, and in_ready falls only when both are full.
module section_container_parser #(
  parameter int unsigned SECTION_LIMIT = scp_pkg::SECTION_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  scp_pkg::scp_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output scp_pkg::scp_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scp_pkg::ADDR_W-1:0] paddr,
  input  logic [scp_pkg::DATA_W-1:0] pwdata,
  output logic [scp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import scp_pkg::*;

  logic               ir_vld_r, ir_vld_nxt;
  scp_in_t            ir_r;
  logic               out_vld_r, out_vld_nxt;
  scp_out_t           out_r;
  scp_out_t           result;
  logic               fire;
  logic [TOTAL_W-1:0] total_length;

  scp_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .total_length (total_length)
  );

  scp_core #(
    .SECTION_LIMIT (SECTION_LIMIT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (fire),
    .item         (ir_r),
    .total_length (total_length),
    .result       (result)
  );

  assign fire = ir_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !ir_vld_r || fire;

  always_comb begin
    ir_vld_nxt = ir_vld_r;
    if (in_valid && in_ready) begin
      ir_vld_nxt = 1'b1;
    end else if (fire) begin
      ir_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ir_vld_r <= ir_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ir_vld_r && out_vld_r && !out_ready))
    else $error("input stalled with room downstream");

  a_ignored_untagged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_IGN) |->
      (out_data.section_index == 3'd0 && !out_data.section_done))
    else $error("ignored item carries a section tag");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.section_done) |->
      (out_data.status == ST_BUSY || out_data.status == ST_COMPLETE))
    else $error("section done with an error status");
`endif

endmodule

### hw/rtl/scp_regs.sv
module scp_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scp_pkg::ADDR_W-1:0]  paddr,
  input  logic [scp_pkg::DATA_W-1:0]  pwdata,
  output logic [scp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [scp_pkg::TOTAL_W-1:0] total_length
);
  import scp_pkg::*;

  logic [TOTAL_W-1:0] total_length_r;
  logic [TOTAL_W-1:0] total_length_nxt;
  logic               hit;

  assign pready = 1'b1;
  assign hit = (paddr[ADDR_W-1:2] == REG_TOTAL_LENGTH);

  always_comb begin
    total_length_nxt = total_length_r;
    if (psel && penable && pwrite && pready && hit) begin
      total_length_nxt = pwdata[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r <= '0;
    end else begin
      total_length_r <= total_length_nxt;
    end
  end

  assign prdata = hit ? {{(DATA_W-TOTAL_W){1'b0}}, total_length_r} : '0;
  assign total_length = total_length_r;

endmodule

### hw/rtl/scp_core.sv
module scp_core #(
  parameter int unsigned SECTION_LIMIT = scp_pkg::SECTION_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  scp_pkg::scp_in_t            item,
  input  logic [scp_pkg::TOTAL_W-1:0] total_length,
  output scp_pkg::scp_out_t           result
);
  import scp_pkg::*;

  localparam int unsigned SL_W = $clog2(SECTION_LIMIT + 1);

  localparam logic [2:0] PH_MAGIC = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_NLEN  = 3'd2;
  localparam logic [2:0] PH_NAME  = 3'd3;
  localparam logic [2:0] PH_DLEN  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_HALT  = 3'd6;

  logic [2:0]          phase_r, phase_nxt;
  logic [1:0]          fbc_r, fbc_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [SL_W-1:0]     sl_r, sl_nxt;
  logic [2:0]          sec_r, sec_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic [TOTAL_W-1:0]  bl_r, bl_nxt;
  logic [2:0]          vd_r, vd_nxt;

  logic [OFFSET_W-1:0] pos;
  logic [31:0]         full;
  logic [32:0]         reach;
  logic [OFFSET_W:0]   head_end;
  logic [7:0]          b;
  logic [1:0]          kind;
  logic [2:0]          sec_out;
  logic                done;

  always_comb begin
    b = item.byte_in;
    phase_nxt = phase_r;
    fbc_nxt = fbc_r;
    acc_nxt = acc_r;
    sl_nxt = sl_r;
    sec_nxt = sec_r;
    off_nxt = off_r;
    bl_nxt = bl_r;
    vd_nxt = vd_r;
    if (item.start_req) begin
      phase_nxt = PH_MAGIC;
      fbc_nxt = '0;
      acc_nxt = '0;
      sl_nxt = '0;
      sec_nxt = '0;
      off_nxt = '0;
      bl_nxt = '0;
      vd_nxt = ST_BUSY;
    end
    kind = KIND_IGN;
    sec_out = '0;
    done = 1'b0;
    pos = off_nxt;
    full = acc_nxt | ({24'd0, b} << {fbc_nxt, 3'b000});
    reach = {16'd0, pos + OFFSET_W'(1)} + {1'b0, full};
    head_end = {1'b0, pos} + (OFFSET_W + 1)'(4);
    if (phase_nxt == PH_HALT || vd_nxt != ST_BUSY) begin
      phase_nxt = PH_HALT;
    end else begin
      off_nxt = pos + OFFSET_W'(1);
      unique case (phase_nxt)
        PH_MAGIC: begin
          kind = KIND_HDR;
          if (pos == '0 && total_length < TOTAL_W'(8)) begin
            vd_nxt = ST_TRUNC;
          end else if (b != MAGIC_WORD[{fbc_nxt, 3'b000} +: 8]) begin
            vd_nxt = ST_BAD_MAGIC;
          end else if (fbc_nxt == 2'd3) begin
            fbc_nxt = '0;
            acc_nxt = '0;
            phase_nxt = PH_COUNT;
          end else begin
            fbc_nxt = fbc_nxt + 2'd1;
          end
        end
        PH_COUNT, PH_NLEN, PH_DLEN: begin
          kind = KIND_HDR;
          if (phase_nxt != PH_COUNT) begin
            sec_out = sec_nxt;
          end
          if (phase_nxt != PH_COUNT && fbc_nxt == 2'd0
              && head_end > {2'b00, total_length}) begin
            vd_nxt = ST_TRUNC;
          end else if (fbc_nxt != 2'd3) begin
            acc_nxt = full;
            fbc_nxt = fbc_nxt + 2'd1;
          end else begin
            fbc_nxt = '0;
            acc_nxt = '0;
            if (phase_nxt == PH_COUNT) begin
              if (full == '0 || full > 32'(SECTION_LIMIT)) begin
                vd_nxt = ST_BAD_COUNT;
              end else begin
                sl_nxt = full[SL_W-1:0];
                sec_nxt = '0;
                phase_nxt = PH_NLEN;
              end
            end else if (phase_nxt == PH_NLEN) begin
              if (full == '0 || full >= 32'(NAME_LIMIT)) begin
                vd_nxt = ST_BAD_NAME;
              end else if (reach > {17'd0, total_length}) begin
                vd_nxt = ST_TRUNC;
              end else begin
                bl_nxt = full[TOTAL_W-1:0];
                phase_nxt = PH_NAME;
              end
            end else begin
              if (reach > {17'd0, total_length}) begin
                vd_nxt = ST_TRUNC;
              end else if (full == '0) begin
                done = 1'b1;
              end else begin
                bl_nxt = full[TOTAL_W-1:0];
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_NAME: begin
          kind = KIND_NAME;
          sec_out = sec_nxt;
          bl_nxt = bl_nxt - TOTAL_W'(1);
          if (bl_nxt == '0) begin
            phase_nxt = PH_DLEN;
            fbc_nxt = '0;
            acc_nxt = '0;
          end
        end
        PH_DATA: begin
          kind = KIND_DATA;
          sec_out = sec_nxt;
          bl_nxt = bl_nxt - TOTAL_W'(1);
          if (bl_nxt == '0) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
      if (done) begin
        sl_nxt = sl_nxt - SL_W'(1);
        if (sl_nxt == '0) begin
          vd_nxt = ST_COMPLETE;
          phase_nxt = PH_HALT;
        end else begin
          sec_nxt = sec_nxt + 3'd1;
          phase_nxt = PH_NLEN;
          fbc_nxt = '0;
          acc_nxt = '0;
        end
      end
    end
    result.kind = kind;
    result.section_index = sec_out;
    result.value = b;
    result.section_done = done;
    result.status = vd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      fbc_r <= '0;
      acc_r <= '0;
      sl_r <= '0;
      sec_r <= '0;
      off_r <= '0;
      bl_r <= '0;
      vd_r <= ST_BUSY;
    end else if (step) begin
      phase_r <= phase_nxt;
      fbc_r <= fbc_nxt;
      acc_r <= acc_nxt;
      sl_r <= sl_nxt;
      sec_r <= sec_nxt;
      off_r <= off_nxt;
      bl_r <= bl_nxt;
      vd_r <= vd_nxt;
    end
  end

`ifndef SYNTH
  a_halt_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |-> (vd_r != ST_BUSY))
    else $error("halted parser without a verdict");

  a_complete_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r == ST_COMPLETE) |-> (phase_r == PH_HALT))
    else $error("complete verdict while the parser still runs");

  a_sections_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sl_r <= SL_W'(SECTION_LIMIT))
    else $error("section count above limit");
`endif

endmodule
